FILE: hdl/dpr_pkg.sv
// Package: shared types, phase and event codes, hex digit decode for the packet receiver.
package dpr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] ev_t;
  typedef logic [1:0] phase_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  localparam phase_t PH_WAIT    = 2'd0;
  localparam phase_t PH_PAYLOAD = 2'd1;
  localparam phase_t PH_CK1     = 2'd2;
  localparam phase_t PH_CK2     = 2'd3;

  localparam ev_t EV_PAYLOAD = 3'd0;
  localparam ev_t EV_OK      = 3'd1;
  localparam ev_t EV_BADSUM  = 3'd2;
  localparam ev_t EV_ACK     = 3'd3;
  localparam ev_t EV_NACK    = 3'd4;
  localparam ev_t EV_INTR    = 3'd5;
  localparam ev_t EV_UNEXP   = 3'd6;

  localparam byte_t CH_INTR  = 8'h03;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_START = 8'h24;
  localparam byte_t CH_HASH  = 8'h23;

  function automatic hex_t hex_decode(byte_t ch);
    hex_t h;
    byte_t t;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch - 8'h30;
      h.val = t[3:0];
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      t = ch - 8'h57;
      h.val = t[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      t = ch - 8'h37;
      h.val = t[3:0];
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

FILE: hdl/dpr_if.sv
// Interfaces: received byte channel and event result channel.
interface dpr_in_if;
  logic           valid;
  logic           ready;
  dpr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpr_out_if;
  logic           valid;
  logic           ready;
  dpr_pkg::ev_t   event_res;
  dpr_pkg::byte_t data;
  dpr_pkg::byte_t computed_sum;
  dpr_pkg::byte_t received_sum;

  modport source (output valid, output event_res, output data, output computed_sum,
                  output received_sum, input ready);
  modport sink   (input valid, input event_res, input data, input computed_sum,
                  input received_sum, output ready);
endinterface

FILE: hdl/debug_packet_receiver.sv
// Top level: debugger remote-protocol packet receiver, byte in, event out.
//
//  channel   dir  fields                                         request taken when
//  in_ch     in   rx_byte[7:0]                                   valid && ready
//  out_ch    out  event_res[2:0] data[7:0] computed_sum[7:0]     valid && ready
//                 received_sum[7:0]
//
// One byte per cycle sustained while results are taken; each byte passes the input
// register, decode and the result register before its result appears.
// Synchronous active-low reset returns to waiting with sums cleared.
// A stalled result holds the result register; one more byte waits in the
// input register, then in_ch.ready drops until the result is taken.
module debug_packet_receiver (
  input  logic    clk,
  input  logic    rst_n,
  dpr_in_if.sink  in_ch,
  dpr_out_if.source out_ch
);
  import dpr_pkg::*;

  logic   s1_v_r;
  byte_t  s1_byte_r;
  logic   s1_adv;

  phase_t phase_r, phase_nxt;
  byte_t  sum_r, sum_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic   hi_bad_r, hi_bad_nxt;

  logic   res_v;
  ev_t    res_ev;
  byte_t  res_cs, res_rs;
  hex_t   hx;
  byte_t  rs_full;

  logic   out_v_r;
  ev_t    out_ev_r;
  byte_t  out_data_r, out_cs_r, out_rs_r;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  assign hx      = hex_decode(s1_byte_r);
  assign rs_full = {hi_r, hx.val};

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    hi_nxt     = hi_r;
    hi_bad_nxt = hi_bad_r;
    res_v      = 1'b0;
    res_ev     = EV_PAYLOAD;
    res_cs     = 8'd0;
    res_rs     = 8'd0;
    if (s1_byte_r == CH_INTR) begin
      res_v  = 1'b1;
      res_ev = EV_INTR;
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (s1_byte_r == CH_PLUS) begin
            res_v  = 1'b1;
            res_ev = EV_ACK;
          end else if (s1_byte_r == CH_MINUS) begin
            res_v  = 1'b1;
            res_ev = EV_NACK;
          end else if (s1_byte_r == CH_START) begin
            sum_nxt   = 8'd0;
            phase_nxt = PH_PAYLOAD;
          end else begin
            res_v  = 1'b1;
            res_ev = EV_UNEXP;
          end
        end
        PH_PAYLOAD: begin
          if (s1_byte_r == CH_HASH) begin
            phase_nxt = PH_CK1;
          end else begin
            sum_nxt = sum_r + s1_byte_r;
            res_v   = 1'b1;
            res_ev  = EV_PAYLOAD;
          end
        end
        PH_CK1: begin
          hi_nxt     = hx.val;
          hi_bad_nxt = hx.bad;
          phase_nxt  = PH_CK2;
        end
        PH_CK2: begin
          phase_nxt = PH_WAIT;
          res_v     = 1'b1;
          res_cs    = sum_r;
          res_rs    = rs_full;
          if (hx.bad || hi_bad_r || rs_full != sum_r) begin
            res_ev = EV_BADSUM;
          end else begin
            res_ev = EV_OK;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      sum_r    <= 8'd0;
      hi_r     <= 4'd0;
      hi_bad_r <= 1'b0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      hi_r     <= hi_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= res_v;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_v) begin
      out_ev_r   <= res_ev;
      out_data_r <= s1_byte_r;
      out_cs_r   <= res_cs;
      out_rs_r   <= res_rs;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.event_res    = out_ev_r;
  assign out_ch.data         = out_data_r;
  assign out_ch.computed_sum = out_cs_r;
  assign out_ch.received_sum = out_rs_r;

  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

  a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_v && (res_ev == EV_OK || res_ev == EV_BADSUM) |=> phase_r == PH_WAIT)
    else $error("checksum result did not return to waiting");

  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ev_r == EV_OK |-> out_cs_r == out_rs_r)
    else $error("packet ok with mismatched sums");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_v && res_ev == EV_PAYLOAD |-> phase_r == PH_PAYLOAD)
    else $error("payload byte outside a packet");

endmodule

FILE: dv/dpr_event_checker.sv
`timescale 1ns / 1ps
// Event checker: predicts receiver events from accepted bytes and compares them with results.
module dpr_event_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  dpr_pkg::byte_t in_rx_byte,
  input  logic           out_valid,
  input  logic           out_ready,
  input  dpr_pkg::ev_t   out_event_res,
  input  dpr_pkg::byte_t out_data,
  input  dpr_pkg::byte_t out_computed_sum,
  input  dpr_pkg::byte_t out_received_sum,
  output int             fail_count,
  output int             pending_count
);
  import dpr_pkg::*;

  typedef struct packed {
    ev_t   ev;
    byte_t data;
    byte_t csum;
    byte_t rsum;
  } rx_event_t;

  rx_event_t  expected_events[$];
  phase_t     rx_phase;
  byte_t      payload_sum;
  logic [3:0] first_nibble;
  logic       first_bad;

  function automatic logic [3:0] hex_nibble(byte_t ch, output logic bad);
    bad = 1'b0;
    if (ch >= "0" && ch <= "9") return ch[3:0];
    if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) return ch[3:0] + 4'd9;
    bad = 1'b1;
    return 4'd0;
  endfunction

  // Advances the protocol state by one byte; returns 1 when the byte yields an event.
  function automatic bit parse_rx_byte(byte_t b, output rx_event_t ev);
    logic       bad;
    logic [3:0] low;
    byte_t      rs;
    ev = {EV_UNEXP, b, 16'h0000};
    if (b == CH_INTR) begin
      ev.ev = EV_INTR;
      return 1'b1;
    end
    case (rx_phase)
      PH_WAIT: begin
        if (b == CH_START) begin
          payload_sum = 8'h00;
          rx_phase = PH_PAYLOAD;
          return 1'b0;
        end
        if (b == CH_PLUS) ev.ev = EV_ACK;
        else if (b == CH_MINUS) ev.ev = EV_NACK;
        return 1'b1;
      end
      PH_PAYLOAD: begin
        if (b == CH_HASH) begin
          rx_phase = PH_CK1;
          return 1'b0;
        end
        payload_sum = payload_sum + b;
        ev.ev = EV_PAYLOAD;
        return 1'b1;
      end
      PH_CK1: begin
        first_nibble = hex_nibble(b, first_bad);
        rx_phase = PH_CK2;
        return 1'b0;
      end
      default: begin
        low = hex_nibble(b, bad);
        rs = {first_nibble, low};
        rx_phase = PH_WAIT;
        ev.ev = (bad || first_bad || rs != payload_sum) ? EV_BADSUM : EV_OK;
        ev.csum = payload_sum;
        ev.rsum = rs;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rx_event_t ev;
    rx_event_t exp_ev;
    if (!rst_n) begin
      expected_events.delete();
      rx_phase = PH_WAIT;
      payload_sum = 8'h00;
      first_nibble = 4'd0;
      first_bad = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d data %0d", out_event_res, out_data);
          fail_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("event_res", int'(exp_ev.ev), int'(out_event_res));
          check_field("data", int'(exp_ev.data), int'(out_data));
          check_field("computed_sum", int'(exp_ev.csum), int'(out_computed_sum));
          check_field("received_sum", int'(exp_ev.rsum), int'(out_received_sum));
        end
      end
      if (in_valid && in_ready) begin
        if (parse_rx_byte(in_rx_byte, ev)) expected_events.push_back(ev);
      end
    end
    pending_count <= expected_events.size();
  end

endmodule

FILE: dv/tb_debug_packet_receiver.sv
`timescale 1ns / 1ps
// Testbench top: drives received byte streams and result stalls, and gives the verdict.
module tb_debug_packet_receiver;
  import dpr_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   sent_count;
  int   fail_count;
  int   pending_count;

  byte_t non_hex_chars[8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};

  dpr_in_if  in_ch ();
  dpr_out_if out_ch ();

  debug_packet_receiver DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dpr_event_checker u_event_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_rx_byte       (in_ch.rx_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_event_res    (out_ch.event_res),
    .out_data         (out_ch.data),
    .out_computed_sum (out_ch.computed_sum),
    .out_received_sum (out_ch.received_sum),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 15);
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(byte_t b);
    if (!steady && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    steady = sent_count >= 500 && sent_count < 800;
  endtask

  function automatic byte_t hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return "0" + 8'(n);
    return (upper ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  // Mostly well-formed requests; some truncated, some with wrong or non-hex checksums.
  task automatic send_random_packet();
    int    len;
    int    kind;
    byte_t b;
    byte_t sum;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    kind = $urandom_range(99);
    sum = 8'h00;
    send_byte(CH_START);
    repeat (len) begin
      b = byte_t'($urandom_range(255));
      if (b == CH_HASH) b = CH_START;
      if ($urandom_range(19) == 0) send_byte(CH_INTR);
      send_byte(b);
      if (b != CH_INTR) sum += b;
    end
    if (kind >= 6) begin
      send_byte(CH_HASH);
      if (kind < 16) sum ^= 8'(1 << $urandom_range(7));
      if (kind >= 16 && kind < 21) send_byte(non_hex_chars[3'($urandom_range(7))]);
      else send_byte(hex_char(sum[7:4], 1'($urandom_range(1))));
      if ($urandom_range(19) == 0) send_byte(CH_INTR);
      if (kind >= 21 && kind < 26) send_byte(non_hex_chars[3'($urandom_range(7))]);
      else send_byte(hex_char(sum[3:0], 1'($urandom_range(1))));
    end
  endtask

  initial begin
    byte_t directed_bytes[$] = '{
      CH_PLUS, CH_MINUS, CH_INTR, 8'h00, 8'hFF,
      CH_START, CH_HASH, "0", "0",
      CH_START, CH_START, CH_INTR, CH_HASH, "2", "4",
      CH_START, 8'hAB, CH_HASH, "a", "B",
      CH_START, CH_HASH, CH_INTR, "g", "0",
      CH_START, CH_HASH, "0", CH_INTR, ":"
    };
    int k;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    while (sent_count < 1200) begin
      if ($urandom_range(99) < 25) begin
        k = $urandom_range(3);
        send_byte(k == 0 ? CH_PLUS : k == 1 ? CH_MINUS : byte_t'($urandom_range(255)));
      end else begin
        send_random_packet();
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: debug_packet_receiver.f
hdl/dpr_pkg.sv
hdl/dpr_if.sv
hdl/debug_packet_receiver.sv
dv/dpr_event_checker.sv
dv/tb_debug_packet_receiver.sv
